// ===== design/lcs_pkg.sv =====
// shared types and constants of the level-set curvature stencil unit
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned LimW     = 31;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInvDx    = 2'd0,
    CfgInvDy    = 2'd1,
    CfgSmallThr = 2'd2,
    CfgCurvLim  = 2'd3
  } cfg_reg_e;

  typedef logic signed [DataW-1:0] phi_t;

  typedef struct packed {
    phi_t phi_center;
    phi_t phi_west;
    phi_t phi_east;
    phi_t phi_south;
    phi_t phi_north;
    phi_t phi_sw;
    phi_t phi_se;
    phi_t phi_nw;
    phi_t phi_ne;
  } lcs_in_t;

  typedef struct packed {
    phi_t curvature;
    logic flat_flag;
  } lcs_out_t;

endpackage

// ===== design/lcs_in_if.sv =====
// stencil input channel: valid, ready and one 3x3 neighborhood
`timescale 1ns / 1ps

interface lcs_in_if import lcs_pkg::*; ();
  logic    valid;
  logic    ready;
  lcs_in_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== design/lcs_out_if.sv =====
// curvature result channel: valid, ready and one result
`timescale 1ns / 1ps

interface lcs_out_if import lcs_pkg::*; ();
  logic     valid;
  logic     ready;
  lcs_out_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== design/levelset_curvature_stencil_unit.sv =====
// top level of the level-set mean curvature stencil unit
`timescale 1ns / 1ps

// takes one 3x3 neighborhood of signed Q15.16 level-set values per transaction and returns
// the central-difference mean curvature, clamped to curvature_limit, or +/-limit with
// flat_flag set when the gradient magnitude is below small_threshold. the unit takes a new
// transaction every cycle while the pipe is not held, and each result passes through seven
// arithmetic stages (differences, scaling products, gradient and hessian terms, numerator),
// a 24-stage square root that settles one root bit per stage, two denominator stages and a
// 31-stage divider that settles one quotient bit per stage, then the output register. a
// skid register behind the output keeps input ready independent of output ready; the whole
// pipe holds only while the skid register is full. configuration is written through the
// plain write port and must only change while no transaction is in flight.
module levelset_curvature_stencil_unit import lcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lcs_in_if.sink             in_i,
  lcs_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i
);

  localparam int unsigned FrontStg = 7;
  localparam int unsigned SqStg    = 24;
  localparam int unsigned DivStg   = 31;
  localparam int unsigned NStg     = FrontStg + SqStg + 2 + DivStg;
  localparam logic [49:0] HClamp   = 50'd1 << 49;

  typedef struct packed {
    logic [47:0] rem;
    logic [23:0] root;
    logic [31:0] num;
    logic [31:0] nsq;
    logic        cle0;
  } sq_t;

  typedef struct packed {
    logic [39:0] den;
    logic [39:0] rem;
    logic [30:0] dvd;
    logic [30:0] quo;
    logic        neg;
    logic        zero;
    logic        clamp;
    logic        flat;
    logic        cle0;
  } dv_t;

  // magnitude helpers, sign-magnitude keeps every shift truncating toward zero
  function automatic logic [35:0] mag36(input logic signed [35:0] v);
    mag36 = v[35] ? 36'(-v) : 36'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat_sm(input logic neg, input logic [71:0] mag);
    if (neg) begin
      sat_sm = (mag >= 72'h8000_0000) ? 32'h8000_0000 : 32'(72'd0 - mag);
    end else begin
      sat_sm = (mag > 72'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  endfunction

  function automatic logic [49:0] clamp_h(input logic [65:0] v);
    clamp_h = (v > 66'(HClamp)) ? HClamp : v[49:0];
  endfunction

  // configuration registers
  logic [DataW-1:0] inv_dx_q, inv_dy_q, thr_q;
  logic [LimW-1:0]  lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_dx_q <= 32'h0001_0000;
      inv_dy_q <= 32'h0001_0000;
      thr_q    <= 32'd1;
      lim_q    <= 31'h0001_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgInvDx:    inv_dx_q <= cfg_wdata_i;
        CfgInvDy:    inv_dy_q <= cfg_wdata_i;
        CfgSmallThr: thr_q    <= cfg_wdata_i;
        CfgCurvLim:  lim_q    <= cfg_wdata_i[LimW-1:0];
        default:     thr_q    <= thr_q;
      endcase
    end
  end

  // handshake and stage valid bits
  logic            en, in_acc, skid_vld_q, out_vld_q, last_vld, out_take;
  logic [NStg-1:0] vld_q;

  assign en         = !skid_vld_q;
  assign in_i.ready = en;
  assign in_acc     = in_i.valid & en;
  assign last_vld   = vld_q[NStg-1];
  assign out_take   = out_vld_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_acc};
    end
  end

  // stage 1: stencil differences
  logic signed [35:0] c_s, w_s, e_s, s_s, n_s, sw_s, se_s, nw_s, ne_s;
  logic signed [35:0] dx_d, dy_d, dxx_d, dyy_d, dxy_d;
  logic [35:0]        dx_m, dy_m, dxx_m, dyy_m, dxy_m;
  logic [32:0]        s1_dx_q, s1_dy_q;
  logic [33:0]        s1_xx_q, s1_yy_q, s1_xy_q;
  logic               s1_dxn_q, s1_dyn_q, s1_xxn_q, s1_yyn_q, s1_xyn_q, s1_cle0_q;

  assign c_s  = {{4{in_i.item.phi_center[31]}}, in_i.item.phi_center};
  assign w_s  = {{4{in_i.item.phi_west[31]}}, in_i.item.phi_west};
  assign e_s  = {{4{in_i.item.phi_east[31]}}, in_i.item.phi_east};
  assign s_s  = {{4{in_i.item.phi_south[31]}}, in_i.item.phi_south};
  assign n_s  = {{4{in_i.item.phi_north[31]}}, in_i.item.phi_north};
  assign sw_s = {{4{in_i.item.phi_sw[31]}}, in_i.item.phi_sw};
  assign se_s = {{4{in_i.item.phi_se[31]}}, in_i.item.phi_se};
  assign nw_s = {{4{in_i.item.phi_nw[31]}}, in_i.item.phi_nw};
  assign ne_s = {{4{in_i.item.phi_ne[31]}}, in_i.item.phi_ne};

  always_comb begin
    dx_d  = e_s - w_s;
    dy_d  = n_s - s_s;
    dxx_d = e_s - (c_s + c_s) + w_s;
    dyy_d = n_s - (c_s + c_s) + s_s;
    dxy_d = ne_s - se_s - nw_s + sw_s;
    dx_m  = mag36(dx_d);
    dy_m  = mag36(dy_d);
    dxx_m = mag36(dxx_d);
    dyy_m = mag36(dyy_d);
    dxy_m = mag36(dxy_d);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q   <= dx_m[32:0];
      s1_dy_q   <= dy_m[32:0];
      s1_xx_q   <= dxx_m[33:0];
      s1_yy_q   <= dyy_m[33:0];
      s1_xy_q   <= dxy_m[33:0];
      s1_dxn_q  <= dx_d[35];
      s1_dyn_q  <= dy_d[35];
      s1_xxn_q  <= dxx_d[35];
      s1_yyn_q  <= dyy_d[35];
      s1_xyn_q  <= dxy_d[35];
      s1_cle0_q <= c_s[35] | (c_s == 36'sd0);
    end
  end

  // stage 2: scale by the reciprocal spacings
  logic [64:0] s2_gx_q, s2_gy_q;
  logic [65:0] s2_xx_q, s2_yy_q, s2_xy_q;
  logic        s2_dxn_q, s2_dyn_q, s2_xxn_q, s2_yyn_q, s2_xyn_q, s2_cle0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_gx_q   <= 65'(s1_dx_q) * 65'(inv_dx_q);
      s2_gy_q   <= 65'(s1_dy_q) * 65'(inv_dy_q);
      s2_xx_q   <= 66'(s1_xx_q) * 66'(inv_dx_q);
      s2_yy_q   <= 66'(s1_yy_q) * 66'(inv_dy_q);
      s2_xy_q   <= 66'(s1_xy_q) * 66'(inv_dx_q);
      s2_dxn_q  <= s1_dxn_q;
      s2_dyn_q  <= s1_dyn_q;
      s2_xxn_q  <= s1_xxn_q;
      s2_yyn_q  <= s1_yyn_q;
      s2_xyn_q  <= s1_xyn_q;
      s2_cle0_q <= s1_cle0_q;
    end
  end

  // stage 3: gradient, and hessian first products clamped where the result saturates anyway
  logic [31:0] s3_gx_q, s3_gy_q;
  logic [49:0] s3_xx_q, s3_yy_q, s3_xy_q;
  logic        s3_xxn_q, s3_yyn_q, s3_xyn_q, s3_cle0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_gx_q   <= sat_sm(s2_dxn_q, 72'(s2_gx_q >> (FracBits + 1)));
      s3_gy_q   <= sat_sm(s2_dyn_q, 72'(s2_gy_q >> (FracBits + 1)));
      s3_xx_q   <= clamp_h(s2_xx_q >> FracBits);
      s3_yy_q   <= clamp_h(s2_yy_q >> FracBits);
      s3_xy_q   <= clamp_h(s2_xy_q >> FracBits);
      s3_xxn_q  <= s2_xxn_q;
      s3_yyn_q  <= s2_yyn_q;
      s3_xyn_q  <= s2_xyn_q;
      s3_cle0_q <= s2_cle0_q;
    end
  end

  // stage 4: gradient products, hessian second products split in halves
  logic [31:0] gx_m, gy_m;
  logic [63:0] s4_ab_q, s4_bb_q, s4_cc_q;
  logic [56:0] s4_xxh_q, s4_xxl_q, s4_yyh_q, s4_yyl_q, s4_xyh_q, s4_xyl_q;
  logic        s4_abn_q, s4_xxn_q, s4_yyn_q, s4_xyn_q, s4_cle0_q;

  assign gx_m = mag32(s3_gx_q);
  assign gy_m = mag32(s3_gy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ab_q   <= 64'(gx_m) * 64'(gy_m);
      s4_bb_q   <= 64'(gx_m) * 64'(gx_m);
      s4_cc_q   <= 64'(gy_m) * 64'(gy_m);
      s4_abn_q  <= s3_gx_q[31] ^ s3_gy_q[31];
      s4_xxh_q  <= 57'(s3_xx_q[49:25]) * 57'(inv_dx_q);
      s4_xxl_q  <= 57'(s3_xx_q[24:0]) * 57'(inv_dx_q);
      s4_yyh_q  <= 57'(s3_yy_q[49:25]) * 57'(inv_dy_q);
      s4_yyl_q  <= 57'(s3_yy_q[24:0]) * 57'(inv_dy_q);
      s4_xyh_q  <= 57'(s3_xy_q[49:25]) * 57'(inv_dy_q);
      s4_xyl_q  <= 57'(s3_xy_q[24:0]) * 57'(inv_dy_q);
      s4_xxn_q  <= s3_xxn_q;
      s4_yyn_q  <= s3_yyn_q;
      s4_xyn_q  <= s3_xyn_q;
      s4_cle0_q <= s3_cle0_q;
    end
  end

  // stage 5: a, b, c and the hessian terms
  logic [82:0] xx_sum, yy_sum, xy_sum;
  logic [31:0] s5_a_q, s5_b_q, s5_c_q, s5_hxx_q, s5_hyy_q, s5_hxy_q;
  logic        s5_cle0_q;

  assign xx_sum = (83'(s4_xxh_q) << 25) + 83'(s4_xxl_q);
  assign yy_sum = (83'(s4_yyh_q) << 25) + 83'(s4_yyl_q);
  assign xy_sum = (83'(s4_xyh_q) << 25) + 83'(s4_xyl_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_a_q    <= sat_sm(s4_abn_q, 72'(s4_ab_q >> FracBits));
      s5_b_q    <= sat_sm(1'b0, 72'(s4_bb_q >> FracBits));
      s5_c_q    <= sat_sm(1'b0, 72'(s4_cc_q >> FracBits));
      s5_hxx_q  <= sat_sm(s4_xxn_q, 72'(xx_sum >> FracBits));
      s5_hyy_q  <= sat_sm(s4_yyn_q, 72'(yy_sum >> FracBits));
      s5_hxy_q  <= sat_sm(s4_xyn_q, 72'(xy_sum >> (FracBits + 2)));
      s5_cle0_q <= s4_cle0_q;
    end
  end

  // stage 6: numerator products and squared gradient norm
  logic [63:0] s6_p1_q, s6_p2_q, s6_p3_q;
  logic [31:0] s6_nsq_q;
  logic        s6_n1_q, s6_n2_q, s6_n3_q, s6_cle0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_p1_q   <= 64'(mag32(s5_a_q)) * 64'(mag32(s5_hxy_q));
      s6_p2_q   <= 64'(mag32(s5_b_q)) * 64'(mag32(s5_hyy_q));
      s6_p3_q   <= 64'(mag32(s5_c_q)) * 64'(mag32(s5_hxx_q));
      s6_n1_q   <= s5_a_q[31] ^ s5_hxy_q[31];
      s6_n2_q   <= s5_b_q[31] ^ s5_hyy_q[31];
      s6_n3_q   <= s5_c_q[31] ^ s5_hxx_q[31];
      s6_nsq_q  <= s5_b_q + s5_c_q;
      s6_cle0_q <= s5_cle0_q;
    end
  end

  // stage 7: numerator, the mixed term carries an extra factor of two
  logic [63:0]        t1, t2, t3;
  logic signed [51:0] v1, v2, v3, numw;
  logic [31:0]        num_d, s7_num_q, s7_nsq_q;
  logic               s7_cle0_q;

  always_comb begin
    t1    = s6_p1_q >> (FracBits - 1);
    t2    = s6_p2_q >> FracBits;
    t3    = s6_p3_q >> FracBits;
    v1    = s6_n1_q ? -$signed(52'(t1)) : $signed(52'(t1));
    v2    = s6_n2_q ? -$signed(52'(t2)) : $signed(52'(t2));
    v3    = s6_n3_q ? -$signed(52'(t3)) : $signed(52'(t3));
    numw  = v1 - v2 - v3;
    if (numw > 52'sh7FFF_FFFF) begin
      num_d = 32'h7FFF_FFFF;
    end else if (numw < -52'sh8000_0000) begin
      num_d = 32'h8000_0000;
    end else begin
      num_d = numw[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_num_q  <= num_d;
      s7_nsq_q  <= s6_nsq_q;
      s7_cle0_q <= s6_cle0_q;
    end
  end

  // square root of nsq in Q16.16, one root bit per stage
  sq_t sq_first;
  sq_t sq_q [SqStg];

  always_comb begin
    sq_first.rem  = {s7_nsq_q, 16'd0};
    sq_first.root = '0;
    sq_first.num  = s7_num_q;
    sq_first.nsq  = s7_nsq_q;
    sq_first.cle0 = s7_cle0_q;
  end

  for (genvar j = 0; j < SqStg; j++) begin : g_sqrt
    localparam int unsigned Bit = SqStg - 1 - j;
    sq_t         cur, nxt;
    logic [48:0] trial;

    if (j == 0) begin : g_head
      assign cur = sq_first;
    end else begin : g_body
      assign cur = sq_q[j-1];
    end

    always_comb begin
      trial = (49'(cur.root) << (Bit + 1)) + (49'd1 << (2 * Bit));
      nxt   = cur;
      if (49'(cur.rem) >= trial) begin
        nxt.rem  = 48'(49'(cur.rem) - trial);
        nxt.root = cur.root | (24'd1 << Bit);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[j] <= nxt;
      end
    end
  end

  // denominator product and flat-cell test
  logic [55:0] sd_p_q;
  logic [31:0] sd_num_q;
  logic        sd_flat_q, sd_cle0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_p_q    <= 56'(sq_q[SqStg-1].nsq) * 56'(sq_q[SqStg-1].root);
      sd_flat_q <= 32'(sq_q[SqStg-1].root) < thr_q;
      sd_num_q  <= sq_q[SqStg-1].num;
      sd_cle0_q <= sq_q[SqStg-1].cle0;
    end
  end

  // divider setup: a quotient of 2^31 or more always clamps, so only 31 bits are formed
  logic [39:0] den_d;
  logic [31:0] nm;
  dv_t         dv_first_q;
  dv_t         dv_q [DivStg];

  assign den_d = 40'(sd_p_q >> FracBits);
  assign nm    = mag32(sd_num_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_first_q.den   <= den_d;
      dv_first_q.rem   <= 40'(nm >> 15);
      dv_first_q.dvd   <= {nm[14:0], 16'd0};
      dv_first_q.quo   <= '0;
      dv_first_q.neg   <= sd_num_q[31];
      dv_first_q.zero  <= (sd_num_q == 32'd0);
      dv_first_q.clamp <= 40'(nm >> 15) >= den_d;
      dv_first_q.flat  <= sd_flat_q;
      dv_first_q.cle0  <= sd_cle0_q;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DivStg; k++) begin : g_div
    localparam int unsigned Bit = DivStg - 1 - k;
    dv_t         cur, nxt;
    logic [40:0] rs;

    if (k == 0) begin : g_head
      assign cur = dv_first_q;
    end else begin : g_body
      assign cur = dv_q[k-1];
    end

    always_comb begin
      rs  = {cur.rem, cur.dvd[Bit]};
      nxt = cur;
      if (rs >= 41'(cur.den)) begin
        nxt.rem      = 40'(rs - 41'(cur.den));
        nxt.quo[Bit] = 1'b1;
      end else begin
        nxt.rem = rs[39:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // result select: flat cell, zero numerator, or clamped quotient with the numerator sign
  dv_t         dv_last;
  logic [31:0] lim32, qe;
  lcs_out_t    res_d;

  assign dv_last = dv_q[DivStg-1];
  assign lim32   = {1'b0, lim_q};

  always_comb begin
    qe = (dv_last.clamp || (dv_last.quo > lim_q)) ? lim32 : {1'b0, dv_last.quo};
    res_d.flat_flag = dv_last.flat;
    if (dv_last.flat) begin
      res_d.curvature = dv_last.cle0 ? (32'd0 - lim32) : lim32;
    end else if (dv_last.zero) begin
      res_d.curvature = '0;
    end else begin
      res_d.curvature = dv_last.neg ? (32'd0 - qe) : qe;
    end
  end

  // output register with skid register behind it
  lcs_out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (last_vld) begin
      if (!out_vld_q || out_take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (last_vld) begin
      if (!out_vld_q || out_take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_q;

  // a held skid entry always has an occupied output register ahead of it
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  // a stalled pipe keeps every stage valid bit
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

  // a result leaving the pipe into a blocked output lands in the skid register
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_vld && en && out_vld_q && !out_o.ready) |=> skid_vld_q)
    else $error("result lost at pipeline exit");

endmodule
